@@ src/moving_average_report_on_change_macros.svh @@
// Assertion macros for the moving average reporting block checker.
`ifndef MOVING_AVERAGE_REPORT_ON_CHANGE_MACROS_SVH
`define MOVING_AVERAGE_REPORT_ON_CHANGE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MARC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MARC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/marc_pkg.sv @@
// Shared constants, types and helpers for the moving average reporting block.
`default_nettype none

package marc_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int VALUE_W        = 16;
  localparam int TIME_W         = 32;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int WIN_W          = 7;
  localparam int WIN_RESET_MAX  = 64;
  localparam int MS_W           = 26;
  localparam int MS_PER_S       = 1000;

  localparam logic [CFG_W-1:0] PRECISION_RST  = 16'd1;
  localparam logic [MS_W-1:0]  MEASURE_MS_RST = 26'd1000;
  localparam logic [MS_W-1:0]  PUBLISH_MS_RST = 26'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECISION        = 2'd0,
    REG_MEASURE_INTERVAL = 2'd1,
    REG_PUBLISH_INTERVAL = 2'd2,
    REG_WINDOW_LENGTH    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_RUN,
    ST_AVG,
    ST_DECIDE
  } state_t;

  function automatic logic [VALUE_W-1:0] abs_diff(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] d;
    d = (VALUE_W+1)'(a) - (VALUE_W+1)'(b);
    return d[VALUE_W] ? VALUE_W'(-d) : VALUE_W'(d);
  endfunction

endpackage

`default_nettype wire

@@ src/moving_average_report_on_change.sv @@
// Moving average of sensor samples with deadband and interval based publish decision.
//
//   channel   direction  handshake            payload
//   cfg_      in         cfg_we               cfg_index, cfg_data
//   in_       in         in_valid / in_ready  func, now_ms, sample_value, sample_ok
//   out_      out        out_valid / out_ready measure_due, publish, last/average value+ok
//
// One transaction steps through accept, ring read, setup, a serial sweep, average, decision.
// The sweep is set by the 32-bit time compares and the restoring divider, both one bit a cycle.
// After reset and after every window_length write, the ring is cleared slot by slot; in_ready
// stays low during that pass. A waiting result holds only the decision step; a new
// transaction is accepted while it waits.
`default_nettype none

module moving_average_report_on_change #(
  parameter int MAX_WINDOW = marc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [marc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [marc_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_func,
  input  wire logic [marc_pkg::TIME_W-1:0]           in_now_ms,
  input  wire logic signed [marc_pkg::VALUE_W-1:0]   in_sample_value,
  input  wire logic                                  in_sample_ok,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       out_measure_due,
  output logic                                       out_publish,
  output logic signed [marc_pkg::VALUE_W-1:0]        out_last_value,
  output logic                                       out_last_ok,
  output logic signed [marc_pkg::VALUE_W-1:0]        out_average_value,
  output logic                                       out_average_ok
);

  localparam int VALUE_W   = marc_pkg::VALUE_W;
  localparam int TIME_W    = marc_pkg::TIME_W;
  localparam int MS_W      = marc_pkg::MS_W;
  localparam int WIN_W     = marc_pkg::WIN_W;
  localparam int CFG_W     = marc_pkg::CFG_W;
  localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = VALUE_W + $clog2(MAX_WINDOW);
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_W     = CNT_W + 1;
  localparam int RUN_N     = (NUM_W > TIME_W) ? NUM_W : TIME_W;
  localparam int STEP_W    = $clog2(RUN_N);
  localparam int ENTRY_W   = VALUE_W + 1;
  localparam int WIN_RESET = (MAX_WINDOW < marc_pkg::WIN_RESET_MAX) ?
                             MAX_WINDOW : marc_pkg::WIN_RESET_MAX;

  marc_pkg::state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0] precision_r;
  logic [MS_W-1:0]  meas_ms_r;
  logic [MS_W-1:0]  pub_ms_r;
  logic [WIN_W-1:0] window_r;
  logic [WIN_W-1:0] win_cfg;
  logic             cfg_win_wr;

  // architectural state
  logic [SLOT_W-1:0]        write_slot_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [TIME_W-1:0]        lmt_r;
  logic [TIME_W-1:0]        lpt_r;
  logic signed [VALUE_W-1:0] pv_r;
  logic                     pv_ok_r;
  logic signed [VALUE_W-1:0] pa_r;
  logic signed [VALUE_W-1:0] last_val_r;
  logic                     last_ok_r;
  logic [SLOT_W-1:0]        clr_addr_r;
  logic                     out_valid_r;

  // transaction payload
  logic                      func_r;
  logic                      ok_r;
  logic signed [VALUE_W-1:0] samp_r;
  logic [TIME_W-1:0]         now_r;

  // divider
  logic [NUM_W-1:0]   num_sh_r;
  logic [DIV_W-1:0]   div_r;
  logic [DIV_W-1:0]   rem_r;
  logic [VALUE_W-1:0] q_r;
  logic               sum_neg_r;
  logic [DIV_W:0]     rem_sh;
  logic [DIV_W:0]     rem_diff;
  logic               q_bit;

  // serial time compares
  logic [TIME_W-1:0] now_sh_r, lmt_sh_r, lpt_sh_r, mi_sh_r, pi_sh_r;
  logic              mbr1_r, mbr2_r, mzero_r;
  logic              pbr1_r, pbr2_r, pzero_r;
  logic              md, pd;
  logic [STEP_W-1:0] step_r;

  // decision
  logic signed [VALUE_W-1:0] avg_r;
  logic                      avg_ok_r;
  logic [VALUE_W-1:0]        d1_r;
  logic [VALUE_W-1:0]        d2;
  logic                      pub_c;
  logic                      due_c;

  // ring access
  logic [SLOT_W:0]       slot_inc;
  logic [SLOT_W-1:0]     slot_next;
  logic                  accept;
  logic                  load_out;
  logic                  clr_done;
  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic                  old_ok;
  logic signed [VALUE_W-1:0] old_val;
  logic signed [SUM_W-1:0]   old_term, new_term;
  logic [SUM_W-1:0]      mag;

  marc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    win_cfg = cfg_data[WIN_W-1:0];
    if (win_cfg == '0) begin
      win_cfg = WIN_W'(1);
    end else if (int'(win_cfg) > MAX_WINDOW) begin
      win_cfg = WIN_W'(MAX_WINDOW);
    end
  end

  assign cfg_win_wr = cfg_we &&
                      (marc_pkg::cfg_reg_t'(cfg_index) == marc_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    slot_inc  = {1'b0, write_slot_r} + (SLOT_W+1)'(1);
    slot_next = slot_inc[SLOT_W-1:0];
    if ((int'(slot_inc) >= int'(window_r)) || (int'(slot_inc) >= MAX_WINDOW)) begin
      slot_next = '0;
    end
  end

  assign clr_done = (clr_addr_r == SLOT_W'(MAX_WINDOW - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      marc_pkg::ST_CLEAR: begin
        if (clr_done) state_nxt = marc_pkg::ST_IDLE;
      end
      marc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = marc_pkg::ST_READ;
      end
      marc_pkg::ST_READ:  state_nxt = marc_pkg::ST_PREP;
      marc_pkg::ST_PREP:  state_nxt = marc_pkg::ST_RUN;
      marc_pkg::ST_RUN: begin
        if (step_r == STEP_W'(RUN_N - 1)) state_nxt = marc_pkg::ST_AVG;
      end
      marc_pkg::ST_AVG:   state_nxt = marc_pkg::ST_DECIDE;
      marc_pkg::ST_DECIDE: begin
        if (!out_valid_r || out_ready) state_nxt = marc_pkg::ST_IDLE;
      end
      default: state_nxt = marc_pkg::ST_CLEAR;
    endcase
    if (cfg_win_wr) begin
      state_nxt = marc_pkg::ST_CLEAR;
    end
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == marc_pkg::ST_IDLE);
    accept    = in_ready && in_valid;
    ram_re    = accept && in_func;
    load_out  = (state_r == marc_pkg::ST_DECIDE) && (!out_valid_r || out_ready);
    ram_we    = 1'b0;
    ram_waddr = write_slot_r;
    ram_wdata = '0;
    case (state_r)
      marc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      marc_pkg::ST_READ: begin
        ram_we    = func_r;
        ram_wdata = {ok_r, ok_r ? samp_r : VALUE_W'(0)};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ring update terms
  always_comb begin
    old_ok   = ram_rdata[VALUE_W];
    old_val  = signed'(ram_rdata[VALUE_W-1:0]);
    old_term = old_ok ? SUM_W'(old_val) : '0;
    new_term = ok_r ? SUM_W'(samp_r) : '0;
    mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  end

  // divider step
  always_comb begin
    rem_sh   = {rem_r, num_sh_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, div_r};
    q_bit    = (rem_sh >= {1'b0, div_r});
  end

  // serial difference bits
  assign md = now_sh_r[0] ^ lmt_sh_r[0] ^ mbr1_r;
  assign pd = now_sh_r[0] ^ lpt_sh_r[0] ^ pbr1_r;

  // publish decision
  always_comb begin
    d2    = marc_pkg::abs_diff(pa_r, avg_r);
    due_c = mzero_r || !mbr2_r;
    if (!last_ok_r) begin
      pub_c = 1'b0;
    end else if (!pv_ok_r) begin
      pub_c = 1'b1;
    end else if (pv_r == last_val_r) begin
      pub_c = pzero_r || !pbr2_r;
    end else if (d1_r >= precision_r) begin
      pub_c = 1'b1;
    end else if (avg_ok_r && (d2 >= precision_r)) begin
      pub_c = 1'b1;
    end else if (avg_ok_r && (avg_r == last_val_r)) begin
      pub_c = 1'b1;
    end else begin
      pub_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= marc_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      precision_r  <= marc_pkg::PRECISION_RST;
      meas_ms_r    <= marc_pkg::MEASURE_MS_RST;
      pub_ms_r     <= marc_pkg::PUBLISH_MS_RST;
      window_r     <= WIN_W'(WIN_RESET);
      write_slot_r <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      lmt_r        <= '0;
      lpt_r        <= '0;
      pv_r         <= '0;
      pv_ok_r      <= 1'b0;
      pa_r         <= '0;
      last_val_r   <= '0;
      last_ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == marc_pkg::ST_CLEAR && !clr_done) begin
        clr_addr_r <= clr_addr_r + SLOT_W'(1);
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (accept && in_func) begin
        lmt_r        <= in_now_ms;
        write_slot_r <= slot_next;
      end

      if (state_r == marc_pkg::ST_READ && func_r) begin
        sum_r      <= sum_r - old_term + new_term;
        cnt_r      <= cnt_r - CNT_W'(old_ok) + CNT_W'(ok_r);
        last_val_r <= ok_r ? samp_r : VALUE_W'(0);
        last_ok_r  <= ok_r;
      end

      if (load_out && pub_c) begin
        lpt_r   <= now_r;
        pv_r    <= last_val_r;
        pv_ok_r <= 1'b1;
        pa_r    <= avg_r;
      end

      if (cfg_we) begin
        case (marc_pkg::cfg_reg_t'(cfg_index))
          marc_pkg::REG_PRECISION:        precision_r <= cfg_data;
          marc_pkg::REG_MEASURE_INTERVAL: meas_ms_r <= MS_W'(cfg_data) *
                                                       MS_W'(marc_pkg::MS_PER_S);
          marc_pkg::REG_PUBLISH_INTERVAL: pub_ms_r <= MS_W'(cfg_data) *
                                                      MS_W'(marc_pkg::MS_PER_S);
          marc_pkg::REG_WINDOW_LENGTH: begin
            window_r     <= win_cfg;
            clr_addr_r   <= '0;
            write_slot_r <= '0;
            sum_r        <= '0;
            cnt_r        <= '0;
            last_val_r   <= '0;
            last_ok_r    <= 1'b0;
          end
          default: precision_r <= precision_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      marc_pkg::ST_IDLE: begin
        func_r <= in_func;
        ok_r   <= in_sample_ok;
        samp_r <= in_sample_value;
        now_r  <= in_now_ms;
      end
      marc_pkg::ST_PREP: begin
        num_sh_r  <= {mag, 1'b0} + NUM_W'(cnt_r);
        div_r     <= {cnt_r, 1'b0};
        rem_r     <= '0;
        q_r       <= '0;
        sum_neg_r <= sum_r[SUM_W-1];
        now_sh_r  <= now_r;
        lmt_sh_r  <= lmt_r;
        lpt_sh_r  <= lpt_r;
        mi_sh_r   <= TIME_W'(meas_ms_r);
        pi_sh_r   <= TIME_W'(pub_ms_r);
        mbr1_r    <= 1'b0;
        mbr2_r    <= 1'b0;
        mzero_r   <= 1'b1;
        pbr1_r    <= 1'b0;
        pbr2_r    <= 1'b0;
        pzero_r   <= 1'b1;
        step_r    <= '0;
      end
      marc_pkg::ST_RUN: begin
        step_r <= step_r + STEP_W'(1);
        if (int'(step_r) < NUM_W) begin
          num_sh_r <= num_sh_r << 1;
          q_r      <= {q_r[VALUE_W-2:0], q_bit};
          rem_r    <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
        if (int'(step_r) < TIME_W) begin
          mbr1_r   <= (!now_sh_r[0] && lmt_sh_r[0]) ||
                      (!(now_sh_r[0] ^ lmt_sh_r[0]) && mbr1_r);
          mbr2_r   <= (!md && mi_sh_r[0]) || (!(md ^ mi_sh_r[0]) && mbr2_r);
          mzero_r  <= mzero_r && !lmt_sh_r[0];
          pbr1_r   <= (!now_sh_r[0] && lpt_sh_r[0]) ||
                      (!(now_sh_r[0] ^ lpt_sh_r[0]) && pbr1_r);
          pbr2_r   <= (!pd && pi_sh_r[0]) || (!(pd ^ pi_sh_r[0]) && pbr2_r);
          pzero_r  <= pzero_r && !lpt_sh_r[0];
          now_sh_r <= now_sh_r >> 1;
          lmt_sh_r <= lmt_sh_r >> 1;
          lpt_sh_r <= lpt_sh_r >> 1;
          mi_sh_r  <= mi_sh_r >> 1;
          pi_sh_r  <= pi_sh_r >> 1;
        end
      end
      marc_pkg::ST_AVG: begin
        avg_ok_r <= (cnt_r != '0);
        if (cnt_r == '0) begin
          avg_r <= '0;
        end else begin
          avg_r <= sum_neg_r ? signed'(VALUE_W'(-q_r)) : signed'(q_r);
        end
        d1_r <= marc_pkg::abs_diff(pv_r, last_val_r);
      end
      marc_pkg::ST_DECIDE: begin
        if (load_out) begin
          out_measure_due   <= due_c;
          out_publish       <= pub_c;
          out_last_value    <= last_val_r;
          out_last_ok       <= last_ok_r;
          out_average_value <= avg_r;
          out_average_ok    <= avg_ok_r;
        end
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ src/marc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module marc_ram #(
  parameter int WIDTH = marc_pkg::VALUE_W + 1,
  parameter int DEPTH = marc_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/marc_checker.sv @@
// Port-level checker for the moving average reporting block, with its bind.
`default_nettype none
`include "moving_average_report_on_change_macros.svh"

module marc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                out_measure_due,
  input wire logic                                out_publish,
  input wire logic signed [marc_pkg::VALUE_W-1:0] out_last_value,
  input wire logic                                out_last_ok,
  input wire logic signed [marc_pkg::VALUE_W-1:0] out_average_value,
  input wire logic                                out_average_ok
);

  `MARC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_publish) && $stable(out_measure_due) && $stable(out_last_value) && $stable(out_average_value), "result changed while stalled")

  `MARC_ASSERT_IMP(a_no_pub_invalid, out_valid && !out_last_ok, !out_publish && (out_last_value == '0), "publish or value on invalid last entry")

  `MARC_ASSERT_IMP(a_avg_zero, out_valid && !out_average_ok, out_average_value == '0, "average nonzero without valid entries")

  `MARC_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken while busy")

endmodule

bind moving_average_report_on_change marc_checker u_marc_checker (.*);

`default_nettype wire
